FILE: hdl/wrs_pkg.sv
// Shared types, codes and defaults for the weighted random selector.
package wrs_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int WEIGHT_BITS_DEF = 32;

    localparam logic [2:0] ACT_INSERT     = 3'd0;
    localparam logic [2:0] ACT_DELETE     = 3'd1;
    localparam logic [2:0] ACT_SET_WEIGHT = 3'd2;
    localparam logic [2:0] ACT_CLEAR      = 3'd3;
    localparam logic [2:0] ACT_SAMPLE     = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] entry_id;
        logic [31:0] weight;
        logic [63:0] random_word;
    } request_t;

    typedef struct packed {
        logic [15:0] selected_id;
        logic [1:0]  status;
    } response_t;

    typedef struct packed {
        logic id_we;
        logic weight_we;
        logic start_we;
    } table_we_t;

endpackage

FILE: hdl/wrs_table.sv
// Entry table: identifier, weight and start offset memories with a shared read address.
module wrs_table #(
    parameter int DEPTH = wrs_pkg::CAPACITY_DEF,
    parameter int WB    = wrs_pkg::WEIGHT_BITS_DEF,
    parameter int TW    = wrs_pkg::WEIGHT_BITS_DEF + $clog2(wrs_pkg::CAPACITY_DEF)
) (
    input  logic                      clk,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [15:0]               rd_id,
    output logic [WB-1:0]             rd_weight,
    output logic [TW-1:0]             rd_start,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  wrs_pkg::table_we_t        we,
    input  logic [15:0]               wr_id,
    input  logic [WB-1:0]             wr_weight,
    input  logic [TW-1:0]             wr_start
);
    import wrs_pkg::*;

    logic [15:0]   id_mem     [DEPTH];
    logic [WB-1:0] weight_mem [DEPTH];
    logic [TW-1:0] start_mem  [DEPTH];

    logic [15:0]   rd_id_reg;
    logic [WB-1:0] rd_weight_reg;
    logic [TW-1:0] rd_start_reg;

    always_ff @(posedge clk)
    begin
        if (we.id_we)
        begin
            id_mem[wr_addr] <= wr_id;
        end
        if (we.weight_we)
        begin
            weight_mem[wr_addr] <= wr_weight;
        end
        if (we.start_we)
        begin
            start_mem[wr_addr] <= wr_start;
        end
        rd_id_reg     <= id_mem[rd_addr];
        rd_weight_reg <= weight_mem[rd_addr];
        rd_start_reg  <= start_mem[rd_addr];
    end

    assign rd_id     = rd_id_reg;
    assign rd_weight = rd_weight_reg;
    assign rd_start  = rd_start_reg;

endmodule

FILE: hdl/wrs_mul.sv
// Iterative 64 x 64 multiplier built on one 32 x 32 unit; returns the high 64 bits.
module wrs_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] hi
);
    import wrs_pkg::*;

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [2:0]   step_reg;
    logic         run_reg;
    logic         done_reg;
    logic [63:0]  prod_reg;
    logic [127:0] acc_reg;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [127:0] addend;

    // step[1] picks the half of a, step[2] the half of b; even steps multiply,
    // odd steps add the product in at its weight
    assign a_half = step_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = step_reg[2] ? b_reg[63:32] : b_reg[31:0];

    always_comb
    begin
        case (step_reg[2:1])
            2'b00:   addend = {64'd0, prod_reg};
            2'b11:   addend = {prod_reg, 64'd0};
            default: addend = {32'd0, prod_reg, 32'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg  <= 1'b1;
                step_reg <= 3'd0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            if (!step_reg[0])
            begin
                prod_reg <= a_half * b_half;
            end
            else
            begin
                acc_reg <= acc_reg + addend;
            end
        end
    end

    assign done = done_reg;
    assign hi   = acc_reg[127:64];

endmodule

FILE: hdl/weighted_random_selector.sv
// Weighted random selector: command sequencer over the entry table and the shared multiplier.
//
// Usage: drive request and raise start while busy is low; the item is taken at that
// clock edge. Exactly one result follows per item: response is valid for the single
// cycle in which done is high, and the receiver cannot hold it off.
// Flow per action, with N entries in the table; after a busy item, done rises in
// the same cycle in which busy falls:
//   insert, clear, unknown action, and sample of an empty or zero-weight table:
//     busy stays low, the result comes in the next cycle, a new item may follow at once.
//   set_weight: an id search (which ends the item when the id is absent), then a
//     rebuild of the start offsets over all N entries.
//   delete: the search, a gap-closing shift over the entries above the hit,
//     then the rebuild over the N-1 left.
//   sample: the position on the shared 32 x 32 multiplier (8 steps and a
//     handoff), then a scan up to the hit.
// The table memories are read through one registered port, which sets the one
// entry per cycle pace of every scan.
// Reset empties the table and zeroes the total; the memories are not cleared.
module weighted_random_selector #(
    parameter int CAPACITY    = wrs_pkg::CAPACITY_DEF,
    parameter int WEIGHT_BITS = wrs_pkg::WEIGHT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  wrs_pkg::request_t  request,
    output logic               done,
    output wrs_pkg::response_t response
);
    import wrs_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int TW    = WEIGHT_BITS + IDX_W;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_FIND    = 6'b000010,
        S_SHIFT   = 6'b000100,
        S_REBUILD = 6'b001000,
        S_MUL     = 6'b010000,
        S_SCAN    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]       count_reg, count_next;
    logic [TW-1:0]          total_reg, total_next;
    logic [CNT_W-1:0]       ptr_reg, ptr_next;
    logic                   pv_reg, pv_next;
    logic [IDX_W-1:0]       pidx_reg, pidx_next;
    logic [2:0]             act_reg, act_next;
    logic [15:0]            id_reg, id_next;
    logic [WEIGHT_BITS-1:0] w_reg, w_next;
    logic [TW-1:0]          pos_reg, pos_next;
    logic                   done_reg, done_next;
    logic [15:0]            sel_reg, sel_next;
    logic [1:0]             status_reg, status_next;

    logic [WEIGHT_BITS-1:0] w_in;
    logic                   scanning;
    logic                   issue;
    logic                   scan_end;
    logic [TW:0]            diff;
    logic                   hit;

    logic [IDX_W-1:0]       rd_addr;
    logic [15:0]            rd_id;
    logic [WEIGHT_BITS-1:0] rd_weight;
    logic [TW-1:0]          rd_start;
    logic [IDX_W-1:0]       wr_addr;
    table_we_t              we;
    logic [15:0]            wr_id;
    logic [WEIGHT_BITS-1:0] wr_weight;
    logic [TW-1:0]          wr_start;

    logic                   mul_go;
    logic                   mul_done;
    logic [63:0]            mul_hi;

    wrs_table #(
        .DEPTH (CAPACITY),
        .WB    (WEIGHT_BITS),
        .TW    (TW)
    ) u_table (
        .clk       (clk),
        .rd_addr   (rd_addr),
        .rd_id     (rd_id),
        .rd_weight (rd_weight),
        .rd_start  (rd_start),
        .wr_addr   (wr_addr),
        .we        (we),
        .wr_id     (wr_id),
        .wr_weight (wr_weight),
        .wr_start  (wr_start)
    );

    wrs_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (mul_go),
        .a     (request.random_word),
        .b     (64'(total_reg)),
        .done  (mul_done),
        .hi    (mul_hi)
    );

    assign w_in     = WEIGHT_BITS'(request.weight);
    assign scanning = (state_reg == S_FIND) || (state_reg == S_SHIFT) ||
                      (state_reg == S_REBUILD) || (state_reg == S_SCAN);
    assign issue    = scanning && (ptr_reg < count_reg);
    assign scan_end = !issue && !pv_reg;
    assign rd_addr  = ptr_reg[IDX_W-1:0];

    // zero-weight entries fail the compare on their own: nothing is below zero
    assign diff = {1'b0, pos_reg} - {1'b0, rd_start};
    assign hit  = !diff[TW] && (diff[TW-1:0] < TW'(rd_weight));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        ptr_next    = ptr_reg;
        pv_next     = 1'b0;
        pidx_next   = pidx_reg;
        act_next    = act_reg;
        id_next     = id_reg;
        w_next      = w_reg;
        pos_next    = pos_reg;
        done_next   = 1'b0;
        sel_next    = sel_reg;
        status_next = status_reg;
        mul_go      = 1'b0;
        wr_addr     = pidx_reg;
        we          = '0;
        wr_id       = rd_id;
        wr_weight   = rd_weight;
        wr_start    = total_reg;

        // advance the read pipeline in every scanning state
        if (scanning)
        begin
            pv_next   = issue;
            pidx_next = ptr_reg[IDX_W-1:0];
            if (issue)
            begin
                ptr_next = ptr_reg + CNT_W'(1);
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next = request.action;
                    id_next  = request.entry_id;
                    w_next   = w_in;
                    ptr_next = '0;
                    sel_next = '0;
                    case (request.action)
                        ACT_INSERT:
                        begin
                            done_next = 1'b1;
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                wr_addr     = count_reg[IDX_W-1:0];
                                wr_id       = request.entry_id;
                                wr_weight   = w_in;
                                wr_start    = total_reg;
                                we          = '{id_we: 1'b1, weight_we: 1'b1, start_we: 1'b1};
                                count_next  = count_reg + CNT_W'(1);
                                total_next  = total_reg + TW'(w_in);
                            end
                        end
                        ACT_DELETE, ACT_SET_WEIGHT:
                        begin
                            state_next = S_FIND;
                        end
                        ACT_CLEAR:
                        begin
                            count_next  = '0;
                            total_next  = '0;
                            done_next   = 1'b1;
                            status_next = ST_OK;
                        end
                        ACT_SAMPLE:
                        begin
                            if ((count_reg != '0) && (total_reg != '0))
                            begin
                                mul_go     = 1'b1;
                                state_next = S_MUL;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NONE;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_FIND:
            begin
                if (pv_reg && (rd_id == id_reg))
                begin
                    pv_next = 1'b0;
                    if (act_reg == ACT_DELETE)
                    begin
                        ptr_next   = CNT_W'(pidx_reg) + CNT_W'(1);
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        wr_weight  = w_reg;
                        we         = '{id_we: 1'b0, weight_we: 1'b1, start_we: 1'b0};
                        ptr_next   = '0;
                        total_next = '0;
                        state_next = S_REBUILD;
                    end
                end
                else if (scan_end)
                begin
                    done_next   = 1'b1;
                    sel_next    = '0;
                    status_next = ST_MISSING;
                    state_next  = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                // move each entry above the hit down by one
                if (pv_reg)
                begin
                    wr_addr = pidx_reg - IDX_W'(1);
                    we      = '{id_we: 1'b1, weight_we: 1'b1, start_we: 1'b0};
                end
                else if (scan_end)
                begin
                    count_next = count_reg - CNT_W'(1);
                    total_next = '0;
                    ptr_next   = '0;
                    state_next = S_REBUILD;
                end
            end
            S_REBUILD:
            begin
                if (pv_reg)
                begin
                    we         = '{id_we: 1'b0, weight_we: 1'b0, start_we: 1'b1};
                    total_next = total_reg + TW'(rd_weight);
                end
                else if (scan_end)
                begin
                    done_next   = 1'b1;
                    sel_next    = '0;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    pos_next   = mul_hi[TW-1:0];
                    ptr_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (pv_reg && hit)
                begin
                    done_next   = 1'b1;
                    sel_next    = rd_id;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
                else if (scan_end)
                begin
                    done_next   = 1'b1;
                    sel_next    = '0;
                    status_next = ST_NONE;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            ptr_reg   <= '0;
            pv_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            ptr_reg   <= ptr_next;
            pv_reg    <= pv_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg   <= pidx_next;
        act_reg    <= act_next;
        id_reg     <= id_next;
        w_reg      <= w_next;
        pos_reg    <= pos_next;
        sel_reg    <= sel_next;
        status_reg <= status_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign response = '{selected_id: sel_reg, status: status_reg};

endmodule
